FILE: rtl/tlgt_pkg.sv
package tlgt_pkg;

  // Default field widths
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int TORQUE_BITS_DEF = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 21;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MOTOR_MASS  = 2'd0,
    REG_ARM_MASS    = 2'd1,
    REG_GRAVITY     = 2'd2,
    REG_LINK_LENGTH = 2'd3
  } cfg_reg_t;

  // Register widths and reset values
  localparam int MM_W = 20;
  localparam int AM_W = 20;
  localparam int G_W  = 21;
  localparam int LL_W = 18;

  localparam logic [MM_W-1:0] MOTOR_MASS_RST  = 20'd20775;
  localparam logic [AM_W-1:0] ARM_MASS_RST    = 20'd6554;
  localparam logic [G_W-1:0]  GRAVITY_RST     = 21'd642253;
  localparam logic [LL_W-1:0] LINK_LENGTH_RST = 18'd8520;

  // Datapath widths
  localparam int FRAC_W   = 16;              // Q16 fraction bits
  localparam int PHASE_W  = 32;              // full turn = 2^32
  localparam int Q_SHIFT  = 30;              // Q30 polynomial
  localparam int Z_W      = 31;              // quarter-wave operand, 0..2^30
  localparam int S_W      = 32;              // Horner accumulator
  localparam int SMAG_W   = 17;              // |sin| in Q16, 0..65536
  localparam int LEVER_W  = LL_W + 1;        // signed lever arm
  localparam int GM_W     = G_W + MM_W;      // g*mass, Q32
  localparam int KSUM_W   = GM_W + 4;        // 4*gm + 3*ga + half
  localparam int GAIN_W   = KSUM_W - 1 - 17; // Q33 -> Q16

  localparam logic [Z_W-1:0]    Q30_ONE  = Z_W'(32'h4000_0000);
  localparam logic [SMAG_W-1:0] SMAG_MAX = 17'd65536;

  // Odd Taylor coefficients of sin(pi*z/2), Q30
  localparam int HORNER_CELLS = 4;
  localparam logic [S_W-1:0] SIN_C9 = 32'd172272;
  localparam logic [S_W-1:0] SIN_COEF [HORNER_CELLS] = '{
    32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // Pipeline stage positions
  localparam int ST_FOLD    = 0;
  localparam int ST_SQUARE  = 1;
  localparam int ST_HORNER  = 2;
  localparam int ST_FINAL   = ST_HORNER + HORNER_CELLS;
  localparam int ST_LEVER   = ST_FINAL + 1;
  localparam int ST_PRODUCT = ST_LEVER + 1;
  localparam int ST_OUT     = ST_PRODUCT + 1;
  localparam int NSTAGE     = ST_OUT + 1;

  // Word handed from cell to cell along a sine lane
  typedef struct packed {
    logic [S_W-1:0] s;
    logic [Z_W-1:0] z;
    logic [Z_W-1:0] z2;
    logic           neg;
  } sine_word_t;

endpackage

FILE: rtl/tlgt_channels.sv
interface tlgt_angle_if #(
  parameter int ANGLE_BITS = tlgt_pkg::ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_joint2;
  logic signed [ANGLE_BITS-1:0] angle_joint3;

  modport source (output valid, output angle_joint2, output angle_joint3, input ready);
  modport sink   (input valid, input angle_joint2, input angle_joint3, output ready);
endinterface

interface tlgt_torque_if #(
  parameter int TORQUE_BITS = tlgt_pkg::TORQUE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [TORQUE_BITS-1:0] hold_torque_joint2;
  logic signed [TORQUE_BITS-1:0] hold_torque_joint3;

  modport source (output valid, output hold_torque_joint2, output hold_torque_joint3,
                  input ready);
  modport sink   (input valid, input hold_torque_joint2, input hold_torque_joint3,
                  output ready);
endinterface

FILE: rtl/tlgt_horner_cell.sv
module tlgt_horner_cell #(
  parameter logic [tlgt_pkg::S_W-1:0] COEF = '0
) (
  input  logic                 clk,
  input  logic                 en,
  input  tlgt_pkg::sine_word_t din,
  output tlgt_pkg::sine_word_t dout
);
  import tlgt_pkg::*;

  logic [S_W+Z_W-1:0]         prod;
  logic [S_W+Z_W-Q_SHIFT-1:0] term;
  logic [S_W-1:0]             s_next;

  // s' = COEF - (s*z2 >> 30), floored at zero
  always_comb begin
    prod   = (S_W+Z_W)'(din.s) * (S_W+Z_W)'(din.z2);
    term   = prod[S_W+Z_W-1:Q_SHIFT];
    s_next = (term > {1'b0, COEF}) ? '0 : COEF - term[S_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.s   <= s_next;
      dout.z   <= din.z;
      dout.z2  <= din.z2;
      dout.neg <= din.neg;
    end
  end

endmodule

FILE: rtl/tlgt_sine_lane.sv
module tlgt_sine_lane #(
  parameter int ANGLE_BITS = tlgt_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic [tlgt_pkg::NSTAGE-1:0]         en,
  input  logic [ANGLE_BITS-1:0]               angle,
  input  logic [tlgt_pkg::LL_W-1:0]           link_length,
  output logic signed [tlgt_pkg::LEVER_W-1:0] lever
);
  import tlgt_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [Z_W-1:0]     r;
  logic [Z_W-1:0]     z_next;
  logic [Z_W-1:0]     fold_z;
  logic               fold_neg;
  logic [2*Z_W-1:0]   sq_prod;

  sine_word_t         seed;
  sine_word_t         chain [HORNER_CELLS+1];

  logic [S_W+Z_W-1:0]           fin_prod;
  logic [S_W+Z_W-Q_SHIFT:0]     fin_rnd;
  logic [S_W+Z_W-Q_SHIFT-14:0]  fin_q16;
  logic [SMAG_W-1:0]            smag;
  logic                         smag_neg;

  logic [LL_W+SMAG_W:0]   lev_prod;
  logic [LL_W-1:0]        lev_mag;

  // Fold the phase onto a quarter wave; sign from the half wave
  always_comb begin
    phase  = {angle, {(PHASE_W-ANGLE_BITS){1'b0}}};
    r      = {1'b0, phase[Q_SHIFT-1:0]};
    z_next = phase[Q_SHIFT] ? Q30_ONE - r : r;
  end

  always_ff @(posedge clk) begin
    if (en[ST_FOLD]) begin
      fold_z   <= z_next;
      fold_neg <= phase[PHASE_W-1];
    end
  end

  // z^2 in Q30, seeds the Horner chain
  assign sq_prod = (2*Z_W)'(fold_z) * (2*Z_W)'(fold_z);

  always_ff @(posedge clk) begin
    if (en[ST_SQUARE]) begin
      seed.s   <= SIN_C9;
      seed.z   <= fold_z;
      seed.z2  <= sq_prod[Q_SHIFT +: Z_W];
      seed.neg <= fold_neg;
    end
  end

  assign chain[0] = seed;

  for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_cell
    tlgt_horner_cell #(
      .COEF (SIN_COEF[i])
    ) u_cell (
      .clk  (clk),
      .en   (en[ST_HORNER+i]),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Last multiply by z, round Q30 -> Q16, clamp to one
  always_comb begin
    fin_prod = (S_W+Z_W)'(chain[HORNER_CELLS].s) * (S_W+Z_W)'(chain[HORNER_CELLS].z);
    fin_rnd  = {1'b0, fin_prod[S_W+Z_W-1:Q_SHIFT]} + (S_W+Z_W-Q_SHIFT+1)'(8192);
    fin_q16  = fin_rnd[S_W+Z_W-Q_SHIFT:14];
  end

  always_ff @(posedge clk) begin
    if (en[ST_FINAL]) begin
      smag     <= (fin_q16 > (S_W+Z_W-Q_SHIFT-13)'(SMAG_MAX)) ? SMAG_MAX
                                                               : fin_q16[SMAG_W-1:0];
      smag_neg <= chain[HORNER_CELLS].neg;
    end
  end

  // Lever arm: length * |sin|, rounded to Q16, then signed
  always_comb begin
    lev_prod = (LL_W+SMAG_W+1)'(link_length) * (LL_W+SMAG_W+1)'(smag)
             + (LL_W+SMAG_W+1)'(32768);
    lev_mag  = lev_prod[FRAC_W +: LL_W];
  end

  always_ff @(posedge clk) begin
    if (en[ST_LEVER]) begin
      lever <= smag_neg ? -$signed({1'b0, lev_mag}) : $signed({1'b0, lev_mag});
    end
  end

endmodule

FILE: rtl/tlgt_torque_stage.sv
module tlgt_torque_stage #(
  parameter int TORQUE_BITS = tlgt_pkg::TORQUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en_product,
  input  logic                                en_out,
  input  logic signed [tlgt_pkg::LEVER_W-1:0] lever_a,
  input  logic signed [tlgt_pkg::LEVER_W-1:0] lever_b,
  input  logic [tlgt_pkg::GAIN_W-1:0]         gain2,
  input  logic [tlgt_pkg::GAIN_W-1:0]         gain3,
  output logic signed [TORQUE_BITS-1:0]       torque2,
  output logic signed [TORQUE_BITS-1:0]       torque3
);
  import tlgt_pkg::*;

  localparam int PROD_W = LEVER_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - FRAC_W;

  localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(32768);
  localparam logic signed [RND_W-1:0] TQ_HI =
    {{(RND_W-TORQUE_BITS+1){1'b0}}, {(TORQUE_BITS-1){1'b1}}};
  localparam logic signed [RND_W-1:0] TQ_LO = ~TQ_HI;

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [SUM_W-1:0]  sum2;
  logic signed [SUM_W-1:0]  sum3;
  logic signed [RND_W-1:0]  rnd2;
  logic signed [RND_W-1:0]  rnd3;

  function automatic logic [TORQUE_BITS-1:0] sat(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] y;
    y = x;
    if (x > TQ_HI) y = TQ_HI;
    if (x < TQ_LO) y = TQ_LO;
    return y[TORQUE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en_product) begin
      prod_a <= PROD_W'(lever_a) * PROD_W'($signed({1'b0, gain2}));
      prod_b <= PROD_W'(lever_b) * PROD_W'($signed({1'b0, gain3}));
    end
  end

  // Q32 -> Q16, ties toward +inf: add half, arithmetic shift
  always_comb begin
    sum2 = SUM_W'(prod_a) + SUM_W'(prod_b) + HALF;
    sum3 = -SUM_W'(prod_b) + HALF;
    rnd2 = sum2[SUM_W-1:FRAC_W];
    rnd3 = sum3[SUM_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      torque2 <= sat(rnd2);
      torque3 <= sat(rnd3);
    end
  end

endmodule

FILE: rtl/two_link_gravity_torque.sv
// Gravity holding torques for a two-link planar arm. Each angles transaction
// carries two signed binary joint angles (full scale is +/-pi) and yields one
// torques transaction with the Q8.16 torques that cancel gravity at both
// joints, saturated to the torque width. The block is a 10-stage pipeline:
// a new transaction is taken every cycle while torques.ready is high. Each
// stage stalls only while it is full and the stage after it cannot move,
// so bubbles close up and the input keeps taking transactions while a
// finished one waits at the output register. The stages are, in order:
// fold, square, four Horner cells (one multiply-subtract each), a final
// multiply and the lever-arm multiply, then the gain products and the
// round/saturate stage. Two identical sine lanes run side by side, one for
// the first joint angle and one for the wrapped angle difference.
// The four mass/gravity/length registers are written through
// cfg_we/cfg_index/cfg_data; write them only while no transaction is in
// flight. The gains derived from them settle in the g*mass product and
// gain registers, well before any new transaction needs them.
module two_link_gravity_torque #(
  parameter int ANGLE_BITS  = tlgt_pkg::ANGLE_BITS_DEF,
  parameter int TORQUE_BITS = tlgt_pkg::TORQUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tlgt_angle_if.sink                       angles,
  tlgt_torque_if.source                    torques,
  input  logic                             cfg_we,
  input  logic [tlgt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlgt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlgt_pkg::*;

  // Configuration registers
  logic [MM_W-1:0] motor_mass;
  logic [AM_W-1:0] arm_mass;
  logic [G_W-1:0]  gravity_accel;
  logic [LL_W-1:0] link_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_mass    <= MOTOR_MASS_RST;
      arm_mass      <= ARM_MASS_RST;
      gravity_accel <= GRAVITY_RST;
      link_length   <= LINK_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOTOR_MASS:  motor_mass    <= cfg_data[MM_W-1:0];
        REG_ARM_MASS:    arm_mass      <= cfg_data[AM_W-1:0];
        REG_GRAVITY:     gravity_accel <= cfg_data[G_W-1:0];
        REG_LINK_LENGTH: link_length   <= cfg_data[LL_W-1:0];
        default: ;
      endcase
    end
  end

  // Gains run free; the user keeps config static with transactions in flight,
  // unenforced. g*mm, g*ma Q32; K2 = 2gm+1.5ga, K3 = gm+0.5ga rounded to Q16.
  logic [GM_W-1:0]   grav_mm;
  logic [GM_W-1:0]   grav_am;
  logic [KSUM_W-1:0] ksum2;
  logic [KSUM_W-1:0] ksum3;
  logic [GAIN_W-1:0] gain2;
  logic [GAIN_W-1:0] gain3;

  always_ff @(posedge clk) begin
    grav_mm <= GM_W'(gravity_accel) * GM_W'(motor_mass);
    grav_am <= GM_W'(gravity_accel) * GM_W'(arm_mass);
  end

  always_comb begin
    ksum2 = {KSUM_W'(grav_mm) << 2} + (KSUM_W'(grav_am) << 1) + KSUM_W'(grav_am)
          + KSUM_W'(65536);
    ksum3 = (KSUM_W'(grav_mm) << 1) + KSUM_W'(grav_am) + KSUM_W'(65536);
  end

  always_ff @(posedge clk) begin
    gain2 <= ksum2[KSUM_W-2:17];
    gain3 <= ksum3[KSUM_W-2:17];
  end

  // Stage valids and per-stage advance; a stage moves when empty or
  // when the next one moves.
  logic [NSTAGE-1:0] stage_valid;
  logic [NSTAGE-1:0] stage_valid_next;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !stage_valid[NSTAGE-1] || torques.ready;
    for (int k = NSTAGE-2; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
    stage_valid_next = stage_valid;
    if (en[0]) stage_valid_next[0] = angles.valid;
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) stage_valid_next[k] = stage_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign angles.ready  = en[0];
  assign torques.valid = stage_valid[NSTAGE-1];

  // Angle difference wraps modulo a full turn
  logic [ANGLE_BITS-1:0] angle_diff;
  assign angle_diff = ANGLE_BITS'(angles.angle_joint2) - ANGLE_BITS'(angles.angle_joint3);

  logic signed [LEVER_W-1:0] lever_a;
  logic signed [LEVER_W-1:0] lever_b;

  tlgt_sine_lane #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_lane_a (
    .clk         (clk),
    .en          (en),
    .angle       (ANGLE_BITS'(angles.angle_joint2)),
    .link_length (link_length),
    .lever       (lever_a)
  );

  tlgt_sine_lane #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_lane_b (
    .clk         (clk),
    .en          (en),
    .angle       (angle_diff),
    .link_length (link_length),
    .lever       (lever_b)
  );

  // t2 = a*K2 + b*K3, t3 = -b*K3
  tlgt_torque_stage #(
    .TORQUE_BITS (TORQUE_BITS)
  ) u_torque (
    .clk        (clk),
    .en_product (en[ST_PRODUCT]),
    .en_out     (en[ST_OUT]),
    .lever_a    (lever_a),
    .lever_b    (lever_b),
    .gain2      (gain2),
    .gain3      (gain3),
    .torque2    (torques.hold_torque_joint2),
    .torque3    (torques.hold_torque_joint3)
  );

endmodule
